// ----- hdl/dq_pkg.sv -----
// ----------------------------------------------------------------------------
// dq_pkg
// Shared constants, codes and types for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

  localparam int DATA_W        = 32;
  localparam int DEFAULT_DEPTH = 64;
  localparam int MODE_W        = 3;
  localparam int STATUS_W      = 2;

  localparam logic [DATA_W-1:0] INT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

  // operation codes carried in a request
  localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
  localparam logic [MODE_W-1:0] MODE_PUSH_REAR  = 3'd1;
  localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_POP_REAR   = 3'd3;
  localparam logic [MODE_W-1:0] MODE_PEEK       = 3'd4;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FETCH,
    S_DELIVER
  } dq_state_t;

endpackage

// ----- hdl/double_ended_queue_top.sv -----
// Sequencing: an accepted request passes the fetch and deliver states before
//   its result is loaded, and no new request is taken until idle again; this
//   follows the accept / store read / result load sequence around the single
//   registered read port of the word store.
// Reset: synchronous, active low; clears head, count, sequencer and result
//   valid. Store contents are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Bounded double-ended queue of signed words over a circular word store.
// ----------------------------------------------------------------------------
module double_ended_queue_top #(
  parameter int DEPTH = dq_pkg::DEFAULT_DEPTH,
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [dq_pkg::MODE_W-1:0]          in_mode,
  input  logic signed [dq_pkg::DATA_W-1:0]   in_data_value,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [dq_pkg::STATUS_W-1:0]        out_status,
  output logic signed [dq_pkg::DATA_W-1:0]   out_popped_value,
  output logic signed [dq_pkg::DATA_W-1:0]   out_front_word,
  output logic signed [dq_pkg::DATA_W-1:0]   out_rear_word,
  output logic [CW-1:0]                      out_entry_count,
  output logic                               out_is_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic                      mem_we;
  logic [AW-1:0]             mem_waddr;
  logic [dq_pkg::DATA_W-1:0] mem_wdata;
  logic                      mem_re;
  logic [AW-1:0]             mem_raddr;
  logic [dq_pkg::DATA_W-1:0] mem_rdata;

  dq_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  dq_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_data_value    (in_data_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_front_word   (out_front_word),
    .out_rear_word    (out_rear_word),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .mem_we           (mem_we),
    .mem_waddr        (mem_waddr),
    .mem_wdata        (mem_wdata),
    .mem_re           (mem_re),
    .mem_raddr        (mem_raddr),
    .mem_rdata        (mem_rdata)
  );

endmodule

// ----- hdl/dq_store.sv -----
// ----------------------------------------------------------------------------
// dq_store
// Word store of the queue: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dq_store #(
  parameter int DEPTH = dq_pkg::DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [dq_pkg::DATA_W-1:0] wr_data,
  input  logic                      rd_en,
  input  logic [AW-1:0]             rd_addr,
  output logic [dq_pkg::DATA_W-1:0] rd_data
);

  logic [dq_pkg::DATA_W-1:0] mem [DEPTH];
  logic [dq_pkg::DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ----- hdl/dq_ctrl.sv -----
// ----------------------------------------------------------------------------
// dq_ctrl
// Queue control: head and count, cached end words, request sequencing and
// the result register.
// ----------------------------------------------------------------------------
module dq_ctrl #(
  parameter int DEPTH = dq_pkg::DEFAULT_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [dq_pkg::MODE_W-1:0]   in_mode,
  input  logic [dq_pkg::DATA_W-1:0]   in_data_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [dq_pkg::STATUS_W-1:0] out_status,
  output logic [dq_pkg::DATA_W-1:0]   out_popped_value,
  output logic [dq_pkg::DATA_W-1:0]   out_front_word,
  output logic [dq_pkg::DATA_W-1:0]   out_rear_word,
  output logic [CW-1:0]               out_entry_count,
  output logic                        out_is_empty,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [dq_pkg::DATA_W-1:0]   mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [dq_pkg::DATA_W-1:0]   mem_rdata
);

  localparam int SW = CW + 1;

  dq_pkg::dq_state_t state_r, state_nxt;

  logic [AW-1:0]                 head_r, head_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [dq_pkg::DATA_W-1:0]     front_r, front_nxt;
  logic [dq_pkg::DATA_W-1:0]     rear_r, rear_nxt;
  logic [dq_pkg::DATA_W-1:0]     popped_r, popped_nxt;
  logic [dq_pkg::STATUS_W-1:0]   status_r, status_nxt;
  logic                          fix_front_r, fix_front_nxt;
  logic                          fix_rear_r, fix_rear_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic [dq_pkg::STATUS_W-1:0]   out_status_r;
  logic [dq_pkg::DATA_W-1:0]     out_popped_r, out_front_r, out_rear_r;
  logic [CW-1:0]                 out_count_r;
  logic                          out_empty_r;

  logic          accept;
  logic          load_out;
  logic          is_full, is_zero, is_one;
  logic [AW-1:0] head_dec, head_inc;
  logic [SW-1:0] tail_sum, tail_wrap, last_sum, last_wrap;
  logic [AW-1:0] tail_pos, last_pos;

  // ---------------------------------------------------------------- FSM
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dq_pkg::S_IDLE:    if (in_valid) state_nxt = dq_pkg::S_FETCH;
      dq_pkg::S_FETCH:   state_nxt = dq_pkg::S_DELIVER;
      dq_pkg::S_DELIVER: if (!out_valid_r || out_ready) state_nxt = dq_pkg::S_IDLE;
      default:           state_nxt = dq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    load_out = 1'b0;
    unique case (state_r)
      dq_pkg::S_IDLE:    in_ready = 1'b1;
      dq_pkg::S_FETCH:   ;
      dq_pkg::S_DELIVER: load_out = !out_valid_r || out_ready;
      default:           ;
    endcase
  end

  assign accept = in_valid && in_ready;

  // ---------------------------------------------------------------- index maths
  assign is_full = (count_r == CW'(DEPTH));
  assign is_zero = (count_r == '0);
  assign is_one  = (count_r == CW'(1));

  assign head_dec = (head_r == '0) ? AW'(DEPTH - 1) : head_r - 1'b1;
  assign head_inc = (head_r == AW'(DEPTH - 1)) ? '0 : head_r + 1'b1;

  // slot just past the rear
  assign tail_sum  = SW'(head_r) + SW'(count_r);
  assign tail_wrap = (tail_sum >= SW'(DEPTH)) ? tail_sum - SW'(DEPTH) : tail_sum;
  assign tail_pos  = tail_wrap[AW-1:0];

  // slot before the rear, meaningful only with two or more words stored
  assign last_sum  = SW'(head_r) + SW'(count_r) - SW'(2);
  assign last_wrap = (last_sum >= SW'(DEPTH)) ? last_sum - SW'(DEPTH) : last_sum;
  assign last_pos  = last_wrap[AW-1:0];

  // ---------------------------------------------------------------- datapath
  always_comb begin
    head_nxt      = head_r;
    count_nxt     = count_r;
    front_nxt     = front_r;
    rear_nxt      = rear_r;
    popped_nxt    = popped_r;
    status_nxt    = status_r;
    fix_front_nxt = 1'b0;
    fix_rear_nxt  = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = tail_pos;
    mem_wdata     = in_data_value;
    mem_re        = 1'b0;
    mem_raddr     = head_inc;

    if (accept) begin
      status_nxt = dq_pkg::ST_OK;
      popped_nxt = '0;
      unique case (in_mode)
        dq_pkg::MODE_PUSH_FRONT: begin
          if (is_full) begin
            status_nxt = dq_pkg::ST_FULL;
          end else begin
            head_nxt  = head_dec;
            count_nxt = count_r + 1'b1;
            mem_we    = 1'b1;
            mem_waddr = head_dec;
            front_nxt = in_data_value;
            if (is_zero) rear_nxt = in_data_value;
          end
        end
        dq_pkg::MODE_PUSH_REAR: begin
          if (is_full) begin
            status_nxt = dq_pkg::ST_FULL;
          end else begin
            count_nxt = count_r + 1'b1;
            mem_we    = 1'b1;
            mem_waddr = tail_pos;
            rear_nxt  = in_data_value;
            if (is_zero) front_nxt = in_data_value;
          end
        end
        dq_pkg::MODE_POP_FRONT: begin
          if (is_zero) begin
            status_nxt = dq_pkg::ST_EMPTY;
          end else begin
            popped_nxt = front_r;
            head_nxt   = head_inc;
            count_nxt  = count_r - 1'b1;
            // refetch the new front unless the queue drains
            if (!is_one) begin
              mem_re        = 1'b1;
              mem_raddr     = head_inc;
              fix_front_nxt = 1'b1;
            end
          end
        end
        dq_pkg::MODE_POP_REAR: begin
          if (is_zero) begin
            status_nxt = dq_pkg::ST_EMPTY;
          end else begin
            popped_nxt = rear_r;
            count_nxt  = count_r - 1'b1;
            if (!is_one) begin
              mem_re       = 1'b1;
              mem_raddr    = last_pos;
              fix_rear_nxt = 1'b1;
            end
          end
        end
        default: ;  // peek and unused codes leave the state alone
      endcase
    end

    if (state_r == dq_pkg::S_FETCH) begin
      fix_front_nxt = fix_front_r;
      fix_rear_nxt  = fix_rear_r;
      if (fix_front_r) front_nxt = mem_rdata;
      if (fix_rear_r)  rear_nxt  = mem_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::S_IDLE;
      head_r      <= '0;
      count_r     <= '0;
      fix_front_r <= 1'b0;
      fix_rear_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      fix_front_r <= fix_front_nxt;
      fix_rear_r  <= fix_rear_nxt;
    end
  end

  always_ff @(posedge clk) begin
    front_r  <= front_nxt;
    rear_r   <= rear_nxt;
    popped_r <= popped_nxt;
    status_r <= status_nxt;
  end

  // ---------------------------------------------------------------- result register
  assign out_valid_nxt = load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_status_r <= status_r;
      out_popped_r <= popped_r;
      out_front_r  <= is_zero ? dq_pkg::INT_MIN : front_r;
      out_rear_r   <= is_zero ? dq_pkg::INT_MIN : rear_r;
      out_count_r  <= count_r;
      out_empty_r  <= is_zero;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_status       = out_status_r;
  assign out_popped_value = out_popped_r;
  assign out_front_word   = out_front_r;
  assign out_rear_word    = out_rear_r;
  assign out_entry_count  = out_count_r;
  assign out_is_empty     = out_empty_r;

  // ---------------------------------------------------------------- assertions
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("word count exceeds depth");

  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= AW'(DEPTH - 1))
    else $error("head index out of range");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    !(mem_we && mem_re))
    else $error("store written and read in the same cycle");

  a_fetch_once: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == dq_pkg::S_FETCH && !in_ready)
    else $error("request not followed by fetch");

  a_single_fix: assert property (@(posedge clk) disable iff (!rst_n)
    !(fix_front_r && fix_rear_r))
    else $error("both end caches marked for refresh");

endmodule
